/* rtl/mfb_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfb_pkg
// shared types and constants for the monochrome frame buffer drawing core
// ---------------------------------------------------------------------------
package mfb_pkg;

  localparam int unsigned DefPanelWidth  = 128;
  localparam int unsigned DefPanelHeight = 64;
  localparam int unsigned PageRows       = 8;

  localparam logic [1:0] ReqPlot = 2'd0;
  localparam logic [1:0] ReqLine = 2'd1;
  localparam logic [1:0] ReqRect = 2'd2;
  localparam logic [1:0] ReqRead = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] x_start;
    logic [7:0] y_start;
    logic [7:0] x_stop;
    logic [7:0] y_stop;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic       ink;
    logic [9:0] byte_addr;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       is_read;
  } rsp_t;

endpackage

/* rtl/mfb_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfb_front
// command queue between the input port and the drawing engine
// ---------------------------------------------------------------------------
module mfb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  mfb_pkg::req_t req_i,
  output logic          cmd_valid_o,
  input  logic          cmd_take_i,
  output mfb_pkg::req_t cmd_o
);
  import mfb_pkg::*;

  // two-entry queue
  req_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign wr          = push && !full;
  assign rd          = cmd_take_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr) wr_ptr_q <= !wr_ptr_q;
      if (rd) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

/* rtl/mfb_engine.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mfb_engine
// pixel walker and frame store read-modify-write
// ---------------------------------------------------------------------------
module mfb_engine #(
  parameter int unsigned PanelWidth  = mfb_pkg::DefPanelWidth,
  parameter int unsigned PanelHeight = mfb_pkg::DefPanelHeight
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_take_o,
  input  mfb_pkg::req_t cmd_i,
  output logic          empty,
  input  logic          pop,
  output mfb_pkg::rsp_t rsp_o
);
  import mfb_pkg::*;

  localparam int unsigned Pages = (PanelHeight + PageRows - 1) / PageRows;
  localparam int unsigned Bytes = PanelWidth * Pages;
  localparam int unsigned AW    = $clog2(Bytes);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StPix   = 3'd2;
  localparam logic [2:0] StRmw   = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [7:0]    mem [Bytes];
  logic [7:0]    rdata_q;
  logic [2:0]    st_q, st_d;
  logic [AW:0]   clr_q;
  logic [1:0]    kind_q;
  logic          ink_q;
  logic [7:0]    x_q, y_q, xe_q, ye_q, x0_q, w_q, h_q, i_q, j_q;
  logic signed [9:0] run_q, rise_q, acc_q;
  logic          sx_q, sy_q;
  logic [AW-1:0] pos_q;
  logic [2:0]    bit_q;
  logic          oob_q;
  logic          out_full_q;
  rsp_t          out_q;

  // current pixel and line stepping
  logic          on_panel;
  logic [AW-1:0] pos;
  logic signed [10:0] twice;
  logic          stx, sty, last;
  logic [7:0]    rx, ry;

  assign rx = (kind_q == ReqRect) ? x0_q + i_q : x_q;
  assign ry = (kind_q == ReqRect) ? y_q + j_q  : y_q;
  assign on_panel = ({1'b0, rx} < 9'(PanelWidth)) && ({1'b0, ry} < 9'(PanelHeight));
  assign pos = AW'(32'(rx) + 32'(ry / PageRows) * PanelWidth);
  assign twice = {acc_q, 1'b0};
  assign stx = twice >= 11'(rise_q);
  assign sty = twice <= 11'(run_q);

  always_comb begin
    case (kind_q)
      ReqLine: last = (x_q == xe_q) && (y_q == ye_q);
      ReqRect: last = (j_q == h_q - 8'd1) && (i_q == w_q - 8'd1);
      default: last = 1'b1;
    endcase
  end

  assign cmd_take_o = (st_q == StIdle) && !out_full_q;
  assign empty = !out_full_q;
  assign rsp_o = out_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StClear: if (clr_q == (AW+1)'(Bytes - 1)) st_d = StIdle;
      StIdle:  if (cmd_valid_i && !out_full_q) begin
        if (cmd_i.req_type == ReqRead) st_d = StRead;
        else if (cmd_i.req_type == ReqRect &&
                 (cmd_i.rect_width == 8'd0 || cmd_i.rect_height == 8'd0)) st_d = StDone;
        else st_d = StPix;
      end
      StPix:   st_d = on_panel ? StRmw : (last ? StDone : StPix);
      StRmw:   st_d = last ? StDone : StPix;
      StRead:  st_d = StDone;
      StDone:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (st_q == StClear) begin
      mem[clr_q[AW-1:0]] <= 8'd0;
    end else if (st_q == StRmw) begin
      mem[pos_q] <= ink_q ? (rdata_q | (8'd1 << bit_q)) : (rdata_q & ~(8'd1 << bit_q));
    end
    // read data held through the read state for the result word
    if (st_q != StRead) begin
      rdata_q <= mem[(st_q == StIdle) ? AW'(cmd_i.byte_addr) : pos];
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle) begin
      kind_q <= cmd_i.req_type;
      ink_q  <= cmd_i.ink;
      x_q    <= cmd_i.x_start;
      y_q    <= cmd_i.y_start;
      x0_q   <= cmd_i.x_start;
      xe_q   <= cmd_i.x_stop;
      ye_q   <= cmd_i.y_stop;
      w_q    <= cmd_i.rect_width;
      h_q    <= cmd_i.rect_height;
      i_q    <= 8'd0;
      j_q    <= 8'd0;
      oob_q  <= {22'd0, cmd_i.byte_addr} >= 32'(Bytes);
      run_q  <= (cmd_i.x_stop > cmd_i.x_start) ? 10'(cmd_i.x_stop - cmd_i.x_start)
                                               : 10'(cmd_i.x_start - cmd_i.x_stop);
      rise_q <= -((cmd_i.y_stop > cmd_i.y_start) ? 10'(cmd_i.y_stop - cmd_i.y_start)
                                                 : 10'(cmd_i.y_start - cmd_i.y_stop));
      acc_q  <= ((cmd_i.x_stop > cmd_i.x_start) ? 10'(cmd_i.x_stop - cmd_i.x_start)
                                                : 10'(cmd_i.x_start - cmd_i.x_stop))
              - ((cmd_i.y_stop > cmd_i.y_start) ? 10'(cmd_i.y_stop - cmd_i.y_start)
                                                : 10'(cmd_i.y_start - cmd_i.y_stop));
      sx_q   <= cmd_i.x_start < cmd_i.x_stop;
      sy_q   <= cmd_i.y_start < cmd_i.y_stop;
    end else if ((st_q == StPix && !on_panel) || st_q == StRmw) begin
      if (kind_q == ReqLine) begin
        acc_q <= acc_q + (stx ? rise_q : 10'sd0) + (sty ? run_q : 10'sd0);
        if (stx) x_q <= sx_q ? x_q + 8'd1 : x_q - 8'd1;
        if (sty) y_q <= sy_q ? y_q + 8'd1 : y_q - 8'd1;
      end else if (kind_q == ReqRect) begin
        // column-major walk, rows inner
        if (j_q == h_q - 8'd1) begin
          j_q <= 8'd0;
          i_q <= i_q + 8'd1;
        end else begin
          j_q <= j_q + 8'd1;
        end
      end
    end
    if (st_q == StPix) begin
      pos_q <= pos;
      bit_q <= ry[2:0];
    end
    if (st_q == StDone) begin
      out_q.is_read   <= (kind_q == ReqRead);
      out_q.read_data <= (kind_q == ReqRead && !oob_q) ? rdata_q : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= StClear;
      clr_q      <= '0;
      out_full_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StClear) clr_q <= clr_q + 1'b1;
      if (st_q == StDone) out_full_q <= 1'b1;
      else if (pop) out_full_q <= 1'b0;
    end
  end

endmodule

/* rtl/mono_framebuffer_drawing_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mono_framebuffer_drawing_core
// monochrome paged frame store with plot, line, rectangle and read commands
// ---------------------------------------------------------------------------
// After reset the store is zeroed by a clearing pass of one byte per cycle
// over PANEL_WIDTH * ceil(PANEL_HEIGHT/8) bytes (1024 at default size), during
// which no command starts. Commands wait in a two-word queue; the engine then
// handles one at a time, each on-panel pixel a read-modify-write of its byte
// (a pixel state, then a write state) and each off-panel pixel skipped in the
// pixel state; a read uses a read state. A new command starts only once the
// previous result word has been popped. Every command returns one result word.
module mono_framebuffer_drawing_core #(
  parameter int unsigned PANEL_WIDTH  = mfb_pkg::DefPanelWidth,
  parameter int unsigned PANEL_HEIGHT = mfb_pkg::DefPanelHeight
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  mfb_pkg::req_t req_i,
  output logic          empty,
  input  logic          pop,
  output mfb_pkg::rsp_t rsp_o
);
  import mfb_pkg::*;

  logic cmd_valid, cmd_take;
  req_t cmd;

  mfb_front u_front (
    .clk_i, .rst_ni, .push, .full, .req_i,
    .cmd_valid_o (cmd_valid),
    .cmd_take_i  (cmd_take),
    .cmd_o       (cmd)
  );

  mfb_engine #(
    .PanelWidth  (PANEL_WIDTH),
    .PanelHeight (PANEL_HEIGHT)
  ) u_engine (
    .clk_i, .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_take_o  (cmd_take),
    .cmd_i       (cmd),
    .empty, .pop, .rsp_o
  );

endmodule
